### src/knnl_pkg.sv
// Shared constants, payload types and control structs for the k-nearest-neighbor list block.
`timescale 1ns / 1ps

package knnl_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int MAX_NEIGHBORS = 16;
    localparam int DIST_W        = 32;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int CNT_W         = $clog2(MAX_NODES + 1);
    localparam int K_W           = $clog2(MAX_NEIGHBORS + 1);
    localparam int RANK_W        = $clog2(MAX_NEIGHBORS);
    localparam int CFG_W         = CNT_W;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET     = CNT_W'(MAX_NODES);
    localparam logic [K_W-1:0]   NEIGHBOR_COUNT_RESET = K_W'(MAX_NEIGHBORS);

    typedef enum logic [0:0] {
        CFG_NODE_COUNT     = 1'b0,
        CFG_NEIGHBOR_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     matrix_start;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] source_node;
        logic [RANK_W-1:0] rank;
        logic [NODE_W-1:0] neighbor_node;
        logic              last_of_row;
    } neighbor_t;

    typedef struct packed {
        logic accept;
        logic emit_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic row_end;
        logic emit_nonzero;
        logic emit_last;
        logic out_free;
    } ctrl_status_t;

endpackage

### src/knnl_controller.sv
// Controller state machine: accepts distance requests and sequences list emission.
`timescale 1ns / 1ps

module knnl_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  knnl_pkg::ctrl_status_t status,
    output knnl_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.emit_load = 1'b0;
        item_stall    = 1'b1;
        unique case (state_reg)
            S_RUN:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
                if (item_valid && status.row_end && status.emit_nonzero)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit_load = status.out_free;
                if (status.out_free && status.emit_last)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/knnl_datapath.sv
// Datapath: configuration, row/column counters, sorted insertion list and result register.
`timescale 1ns / 1ps

module knnl_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  knnl_pkg::cfg_index_t          cfg_index,
    input  logic [knnl_pkg::CFG_W-1:0]    cfg_data,
    input  knnl_pkg::item_t               item,
    output logic                          neighbor_valid,
    input  logic                          neighbor_stall,
    output knnl_pkg::neighbor_t           neighbor,
    input  knnl_pkg::ctrl_cmd_t           cmd,
    output knnl_pkg::ctrl_status_t        status
);

    localparam int NW = knnl_pkg::NODE_W;
    localparam int CW = knnl_pkg::CNT_W;
    localparam int KW = knnl_pkg::K_W;
    localparam int RW = knnl_pkg::RANK_W;
    localparam int DW = knnl_pkg::DIST_W;
    localparam int MK = knnl_pkg::MAX_NEIGHBORS;

    logic [CW-1:0] node_count_reg;
    logic [KW-1:0] neighbor_count_reg;
    logic [NW-1:0] row_reg;
    logic [NW-1:0] col_reg;
    logic [KW-1:0] fill_reg;
    logic [NW-1:0] emit_row_reg;
    logic [KW-1:0] emit_len_reg;
    logic [RW-1:0] emit_idx_reg;
    logic          out_valid_reg;
    knnl_pkg::neighbor_t out_reg;

    logic signed [DW-1:0] best_dist_reg [MK];
    logic [NW-1:0]        best_id_reg   [MK];

    logic [CW-1:0] eff_n;
    logic [CW-1:0] n_minus_1;
    logic [KW-1:0] k_eff;
    logic [NW-1:0] row_cur;
    logic [NW-1:0] col_cur;
    logic [KW-1:0] fill_cur;
    logic [KW-1:0] len;
    logic [KW-1:0] fill_next;
    logic          ins;
    logic          take;
    logic          row_end;
    logic [CW-1:0] row_inc;
    logic [MK-1:0] ge;
    logic signed [DW-1:0] d;
    logic          emit_last;

    always_comb
    begin
        eff_n = node_count_reg;
        if (node_count_reg < CW'(2))
        begin
            eff_n = CW'(2);
        end
        else if (node_count_reg > CW'(knnl_pkg::MAX_NODES))
        begin
            eff_n = CW'(knnl_pkg::MAX_NODES);
        end
        n_minus_1 = eff_n - CW'(1);

        k_eff = neighbor_count_reg;
        if ({{(CW-KW){1'b0}}, k_eff} > n_minus_1)
        begin
            k_eff = KW'(n_minus_1);
        end
        if (k_eff > KW'(MK))
        begin
            k_eff = KW'(MK);
        end

        row_cur  = item.matrix_start ? '0 : row_reg;
        col_cur  = item.matrix_start ? '0 : col_reg;
        fill_cur = item.matrix_start ? '0 : fill_reg;
        len      = (fill_cur < k_eff) ? fill_cur : k_eff;
        d        = $signed(item.distance);

        ins  = (col_cur != row_cur);
        take = cmd.accept && ins;

        fill_next = (ins && (len < k_eff)) ? len + KW'(1) : len;
        row_end   = ({1'b0, col_cur} >= n_minus_1);
        row_inc   = {1'b0, row_cur} + CW'(1);

        for (int i = 0; i < MK; i++)
        begin
            ge[i] = (KW'(i) < len) && !(d < best_dist_reg[i]);
        end

        emit_last = ({1'b0, emit_idx_reg} + KW'(1)) == emit_len_reg;
    end

    assign status.row_end      = row_end;
    assign status.emit_nonzero = (fill_next != '0);
    assign status.emit_last    = emit_last;
    assign status.out_free     = !out_valid_reg || !neighbor_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg     <= knnl_pkg::NODE_COUNT_RESET;
            neighbor_count_reg <= knnl_pkg::NEIGHBOR_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                knnl_pkg::CFG_NODE_COUNT:     node_count_reg     <= cfg_data;
                knnl_pkg::CFG_NEIGHBOR_COUNT: neighbor_count_reg <= cfg_data[KW-1:0];
                default:                      node_count_reg     <= node_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            fill_reg      <= '0;
            emit_idx_reg  <= '0;
            emit_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (row_end)
                begin
                    fill_reg     <= '0;
                    col_reg      <= '0;
                    row_reg      <= (row_inc >= eff_n) ? '0 : row_inc[NW-1:0];
                    emit_len_reg <= fill_next;
                    emit_idx_reg <= '0;
                end
                else
                begin
                    fill_reg <= fill_next;
                    col_reg  <= col_cur + NW'(1);
                    row_reg  <= row_cur;
                end
            end
            if (cmd.emit_load)
            begin
                emit_idx_reg  <= emit_idx_reg + RW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (!neighbor_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !row_end)
        begin
            emit_row_reg <= emit_row_reg;
        end
        else if (cmd.accept)
        begin
            emit_row_reg <= row_cur;
        end
        for (int i = 0; i < MK; i++)
        begin
            if (take && (KW'(i) < k_eff) && !ge[i])
            begin
                if (i == 0)
                begin
                    best_dist_reg[i] <= d;
                    best_id_reg[i]   <= col_cur;
                end
                else if (ge[(i == 0) ? 0 : i - 1])
                begin
                    best_dist_reg[i] <= d;
                    best_id_reg[i]   <= col_cur;
                end
                else
                begin
                    best_dist_reg[i] <= best_dist_reg[(i == 0) ? 0 : i - 1];
                    best_id_reg[i]   <= best_id_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
        if (cmd.emit_load)
        begin
            out_reg.source_node   <= emit_row_reg;
            out_reg.rank          <= emit_idx_reg;
            out_reg.neighbor_node <= best_id_reg[emit_idx_reg];
            out_reg.last_of_row   <= emit_last;
        end
    end

    assign neighbor_valid = out_valid_reg;
    assign neighbor       = out_reg;

endmodule

### src/k_nearest_neighbor_lists.sv
// Top level of the k-nearest-neighbor list block: controller, datapath and checks.
`timescale 1ns / 1ps

// Streams a square distance matrix in row-major order, one signed element per request,
// and emits for every row the column ids of its K nearest off-diagonal nodes in
// ascending distance (ties go to the lower column), K = min(neighbor_count,
// node_count - 1, 16), with last_of_row on the final one. Each element passes
// through a 16-cell parallel compare-and-shift insertion list. At a row end
// with K > 0 the input stalls while the list drains through the output register
// one neighbor per cycle, held while the result side stalls. matrix_start on an
// element restarts at row 0 column 0.

module k_nearest_neighbor_lists (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  knnl_pkg::cfg_index_t          cfg_index,
    input  logic [knnl_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  knnl_pkg::item_t               item,
    output logic                          neighbor_valid,
    input  logic                          neighbor_stall,
    output knnl_pkg::neighbor_t           neighbor
);

    knnl_pkg::ctrl_cmd_t    cmd;
    knnl_pkg::ctrl_status_t status;

    knnl_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    knnl_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item           (item),
        .neighbor_valid (neighbor_valid),
        .neighbor_stall (neighbor_stall),
        .neighbor       (neighbor),
        .cmd            (cmd),
        .status         (status)
    );

    a_rank_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (neighbor_valid && !neighbor_stall && !neighbor.last_of_row) |=>
        (neighbor_valid &&
         neighbor.rank == knnl_pkg::RANK_W'($past(neighbor.rank) + knnl_pkg::RANK_W'(1))))
        else $error("rank did not advance within a row");

    a_source_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (neighbor_valid && !neighbor_stall && !neighbor.last_of_row) |=>
        (neighbor.source_node == $past(neighbor.source_node)))
        else $error("source node changed within a row");

    a_stall_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        (neighbor_valid && !neighbor.last_of_row) |-> item_stall)
        else $error("request accepted while a row list is draining");

endmodule
